// File: sv/fpcu_pkg.sv
// Shared types and constants for the frustum plane cull unit.
package fpcu_pkg;

  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_SPHERE = 2'd1;
  localparam logic [1:0] FUNC_BOX    = 2'd2;

  localparam int unsigned NUM_PLANES = 6;
  localparam int unsigned MAT_ENTRIES = 16;
  localparam int unsigned PLANE_ENTRIES = 24;
  localparam logic [3:0] LAST_ELEMENT = 4'd15;

  typedef struct packed {
    logic        is_box;
    logic [31:0] center_x;
    logic [31:0] center_y;
    logic [31:0] center_z;
    logic [30:0] radius;
    logic [30:0] extent_x;
    logic [30:0] extent_y;
    logic [30:0] extent_z;
  } test_req_t;

  // Plane pairing: which matrix row each plane combines with row 3, and whether it subtracts.
  function automatic logic [1:0] plane_pair(input logic [2:0] p);
    logic [1:0] r;
    case (p)
      3'd0, 3'd1: r = 2'd0;
      3'd2, 3'd3: r = 2'd1;
      default:    r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic plane_minus(input logic [2:0] p);
    logic r;
    case (p)
      3'd0, 3'd3, 3'd4: r = 1'b1;
      default:          r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// File: sv/frustum_plane_cull_unit.sv
// Top level of the frustum plane cull unit.
//  channel | signals                               | handshake
//  request | start_i, func_i .. extent_z_i         | start_i & !busy_o
//  result  | done_o, inside_res_o                  | done_o, one cycle
// In the back end a test is dequeued, then each plane takes a product phase and a compare phase;
// a two-entry queue lets the front take new tests meanwhile. Loading element 15 rebuilds the
// planes with a bit-serial root and divider, during which busy_o stays high.
// Reset clears matrix and planes to zero. The receiver cannot stall results.
module frustum_plane_cull_unit import fpcu_pkg::*; #(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         func_i,
  input  logic [3:0]         element_index_i,
  input  logic signed [31:0] element_value_i,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic signed [31:0] center_z_i,
  input  logic [30:0]        radius_i,
  input  logic [30:0]        extent_x_i,
  input  logic [30:0]        extent_y_i,
  input  logic [30:0]        extent_z_i,
  output logic               done_o,
  output logic               inside_res_o
);
  test_req_t req, q_req;
  logic q_valid, q_pop, back_busy;
  logic signed [COORD_WIDTH-1:0] planes [PLANE_ENTRIES];

  assign req = '{is_box: func_i == FUNC_BOX, center_x: center_x_i, center_y: center_y_i,
                 center_z: center_z_i, radius: radius_i, extent_x: extent_x_i,
                 extent_y: extent_y_i, extent_z: extent_z_i};

  fpcu_front #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk_i, .rst_ni, .start_i, .func_i, .element_index_i, .element_value_i,
    .req_i(req), .busy_o, .q_valid_o(q_valid), .q_req_o(q_req), .q_pop_i(q_pop),
    .back_busy_i(back_busy), .planes_o(planes)
  );

  fpcu_back #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_req_i(q_req), .q_pop_o(q_pop),
    .busy_o(back_busy), .planes_i(planes), .done_o, .inside_res_o
  );
endmodule

// File: sv/fpcu_front.sv
// Front end: matrix store, plane rebuild (isqrt and divide) and test request queue.
module fpcu_front import fpcu_pkg::*; #(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [1:0]                    func_i,
  input  logic [3:0]                    element_index_i,
  input  logic signed [31:0]            element_value_i,
  input  test_req_t                     req_i,
  output logic                          busy_o,
  output logic                          q_valid_o,
  output test_req_t                     q_req_o,
  input  logic                          q_pop_i,
  input  logic                          back_busy_i,
  output logic signed [COORD_WIDTH-1:0] planes_o [PLANE_ENTRIES]
);
  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned SW = 2 * CW + 2;             // sum of squares width
  localparam int unsigned LW = CW + 1;                 // sqrt width
  localparam int unsigned NW = CW + FRAC_BITS;         // dividend magnitude width
  localparam int unsigned QD = 2;
  localparam logic signed [CW-1:0] SMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] SMIN = {1'b1, {(CW-1){1'b0}}};

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RAW   = 3'd1;
  localparam logic [2:0] S_SQ    = 3'd2;
  localparam logic [2:0] S_SQRT  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_STORE = 3'd5;
  localparam logic [2:0] S_DRAIN = 3'd6;

  logic signed [CW-1:0] mat_q [MAT_ENTRIES];
  logic signed [CW-1:0] pl_q [PLANE_ENTRIES];
  logic [2:0] st_q, st_d;
  logic [2:0] pidx_q;
  logic [1:0] j_q;
  logic signed [CW-1:0] raw_q [4];
  logic [SW-1:0] ssum_q;
  logic [LW-1:0] root_q;
  logic [$clog2(LW+1)-1:0] bit_q;
  logic [NW-1:0] num_q;
  logic [NW:0] quo_q;
  logic [LW:0] rem_q;
  logic [$clog2(NW+1)-1:0] dcnt_q;
  logic signed [CW-1:0] res_q [4];

  // Queue
  test_req_t fifo_q [QD];
  logic rd_q, wr_q;
  logic [1:0] cnt_q;

  logic acc, push, ld;
  assign busy_o = (st_q != S_IDLE) || (cnt_q == 2'(QD));
  assign acc  = start_i && !busy_o;
  assign ld   = acc && func_i == FUNC_LOAD;
  assign push = acc && (func_i == FUNC_SPHERE || func_i == FUNC_BOX);
  assign q_valid_o = cnt_q != 2'd0;
  assign q_req_o = fifo_q[rd_q];

  function automatic logic signed [CW-1:0] sat_c(input logic signed [CW:0] v);
    if (v > $signed({1'b0, SMAX})) return SMAX;
    if (v < $signed({SMIN[CW-1], SMIN})) return SMIN;
    return v[CW-1:0];
  endfunction

  function automatic logic signed [CW-1:0] sat_ld(input logic signed [31:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    if (w > 64'(SMAX)) return SMAX;
    if (w < 64'(SMIN)) return SMIN;
    return CW'(w);
  endfunction

  function automatic logic [CW:0] mag_c(input logic signed [CW-1:0] v);
    logic [CW:0] e;
    e = {v[CW-1], v};
    return v[CW-1] ? -e : e;
  endfunction

  function automatic logic [SW-1:0] sq_c(input logic [CW:0] v);
    return v * v;
  endfunction

  function automatic logic signed [CW-1:0] fin(input logic signed [CW-1:0] v,
                                               input logic [NW:0] q, input logic lb);
    logic [NW+1:0] qq;
    logic [CW-1:0] m;
    qq = {q, lb};
    m  = (qq > (NW+2)'(SMAX)) ? SMAX : qq[CW-1:0];
    return v[CW-1] ? -$signed(m) : $signed(m);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      if (push) begin
        fifo_q[wr_q] <= req_i;
        wr_q <= ~wr_q;
      end
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

  // Trial square for the restoring root and trial subtract for the divider.
  logic [LW-1:0] cand;
  logic [2*LW-1:0] csq;
  logic [LW:0] rshift;
  assign cand   = root_q | (LW'(1) << bit_q);
  assign csq    = cand * cand;
  assign rshift = {rem_q[LW-1:0], num_q[NW-1]};

  logic [1:0] pair;
  logic       minus;
  assign pair  = plane_pair(pidx_q);
  assign minus = plane_minus(pidx_q);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE:  if (ld && element_index_i == LAST_ELEMENT) st_d = S_DRAIN;
      S_DRAIN: if (cnt_q == 2'd0 && !back_busy_i) st_d = S_RAW;
      S_RAW:   st_d = S_SQ;
      S_SQ:    st_d = S_SQRT;
      S_SQRT:  if (bit_q == '0) st_d = S_DIV;
      S_DIV:   if (dcnt_q == '0 && j_q == 2'd3) st_d = S_STORE;
      S_STORE: st_d = (pidx_q == 3'(NUM_PLANES - 1)) ? S_IDLE : S_RAW;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      pidx_q <= '0;
      j_q    <= '0;
      bit_q  <= '0;
      dcnt_q <= '0;
      for (int i = 0; i < MAT_ENTRIES; i++) mat_q[i] <= '0;
      for (int i = 0; i < PLANE_ENTRIES; i++) pl_q[i] <= '0;
    end else begin
      st_q <= st_d;
      if (ld) mat_q[element_index_i] <= sat_ld(element_value_i);
      unique case (st_q)
        S_IDLE: pidx_q <= '0;
        S_RAW: begin
          for (int j = 0; j < 4; j++) begin
            raw_q[j] <= minus
              ? sat_c({mat_q[4*j+3][CW-1], mat_q[4*j+3]} -
                      {mat_q[4*j+pair][CW-1], mat_q[4*j+pair]})
              : sat_c({mat_q[4*j+3][CW-1], mat_q[4*j+3]} +
                      {mat_q[4*j+pair][CW-1], mat_q[4*j+pair]});
          end
        end
        S_SQ: begin
          ssum_q <= sq_c(mag_c(raw_q[0])) + sq_c(mag_c(raw_q[1])) + sq_c(mag_c(raw_q[2]));
          root_q <= '0;
          bit_q  <= ($clog2(LW+1))'(LW - 1);
        end
        S_SQRT: begin
          if (SW'(csq) <= ssum_q) root_q <= cand;
          if (bit_q != '0) bit_q <= bit_q - 1'b1;
          else begin
            j_q    <= '0;
            num_q  <= NW'(mag_c(raw_q[0])) << FRAC_BITS;
            rem_q  <= '0;
            quo_q  <= '0;
            dcnt_q <= ($clog2(NW+1))'(NW - 1);
          end
        end
        S_DIV: begin
          if (rshift >= {1'b0, root_q}) begin
            rem_q <= rshift - {1'b0, root_q};
            quo_q <= {quo_q[NW-1:0], 1'b1};
          end else begin
            rem_q <= rshift;
            quo_q <= {quo_q[NW-1:0], 1'b0};
          end
          num_q <= {num_q[NW-2:0], 1'b0};
          if (dcnt_q != '0) dcnt_q <= dcnt_q - 1'b1;
          else begin
            // quotient done: latch this component, start the next
            res_q[j_q] <= fin(raw_q[j_q], quo_q, rshift >= {1'b0, root_q});
            j_q    <= j_q + 1'b1;
            num_q  <= NW'(mag_c(raw_q[j_q + 2'd1])) << FRAC_BITS;
            rem_q  <= '0;
            quo_q  <= '0;
            dcnt_q <= ($clog2(NW+1))'(NW - 1);
          end
        end
        S_STORE: begin
          for (int j = 0; j < 4; j++)
            pl_q[4*pidx_q+j] <= (ssum_q == '0) ? raw_q[j] : res_q[j];
          pidx_q <= pidx_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign planes_o = pl_q;
endmodule

// File: sv/fpcu_back.sv
// Back end: plane-by-plane sphere and box test over the stored planes.
module fpcu_back import fpcu_pkg::*; #(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  test_req_t                     q_req_i,
  output logic                          q_pop_o,
  output logic                          busy_o,
  input  logic signed [COORD_WIDTH-1:0] planes_i [PLANE_ENTRIES],
  output logic                          done_o,
  output logic                          inside_res_o
);
  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned PW = CW + 34;        // product width
  localparam int unsigned AW = PW + 4;         // accumulator width

  test_req_t r_q;
  logic act_q, ph_q, in_q;
  logic [2:0] p_q;
  logic signed [PW-1:0] pr_q [4];
  logic signed [PW-1:0] xp_q [3];
  logic signed [AW-1:0] sum;
  logic rej;

  assign busy_o  = act_q;
  assign q_pop_o = q_valid_i && !act_q;

  logic signed [CW-1:0] a, b, c, d;
  assign a = planes_i[4*p_q];
  assign b = planes_i[4*p_q+1];
  assign c = planes_i[4*p_q+2];
  assign d = planes_i[4*p_q+3];

  function automatic logic signed [PW-1:0] absmul(input logic signed [CW-1:0] v,
                                                  input logic [30:0] e);
    logic signed [CW:0] m;
    m = v[CW-1] ? -{v[CW-1], v} : {v[CW-1], v};
    return PW'(m) * $signed({1'b0, e});
  endfunction

  // Phase 0 forms all products, phase 1 adds them and compares.
  always_comb begin
    sum = AW'(pr_q[0]) + AW'(pr_q[1]) + AW'(pr_q[2]) + AW'(pr_q[3])
        + AW'(xp_q[0]) + AW'(xp_q[1]) + AW'(xp_q[2]);
    rej = r_q.is_box ? sum[AW-1] : (sum[AW-1] || sum == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      ph_q  <= 1'b0;
      p_q   <= '0;
      in_q  <= 1'b1;
      done_o <= 1'b0;
      inside_res_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (q_pop_o) begin
        r_q   <= q_req_i;
        act_q <= 1'b1;
        ph_q  <= 1'b0;
        p_q   <= '0;
        in_q  <= 1'b1;
      end else if (act_q) begin
        if (!ph_q) begin
          pr_q[0] <= PW'(a) * PW'($signed(r_q.center_x));
          pr_q[1] <= PW'(b) * PW'($signed(r_q.center_y));
          pr_q[2] <= PW'(c) * PW'($signed(r_q.center_z));
          pr_q[3] <= (PW'(d) <<< FRAC_BITS) + (r_q.is_box ? PW'(0) :
                     (PW'($signed({1'b0, r_q.radius})) <<< FRAC_BITS));
          xp_q[0] <= r_q.is_box ? absmul(a, r_q.extent_x) : '0;
          xp_q[1] <= r_q.is_box ? absmul(b, r_q.extent_y) : '0;
          xp_q[2] <= r_q.is_box ? absmul(c, r_q.extent_z) : '0;
          ph_q <= 1'b1;
        end else begin
          ph_q <= 1'b0;
          if (p_q == 3'(NUM_PLANES - 1)) begin
            act_q <= 1'b0;
            done_o <= 1'b1;
            inside_res_o <= in_q && !rej;
          end else begin
            in_q <= in_q && !rej;
            p_q  <= p_q + 1'b1;
          end
        end
      end
    end
  end
endmodule

// File: sv/fpcu_checker.sv
// Port-level checks for the frustum plane cull unit.
module fpcu_checker import fpcu_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o,
  input logic [1:0] func_i,
  input logic [3:0] element_index_i
);
  a_no_done_reset: assert property (@(posedge clk_i) !rst_ni |=> !done_o) else $error("done after reset");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("done held");
  a_rebuild_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && func_i == FUNC_LOAD && element_index_i == LAST_ELEMENT) |=> busy_o)
    else $error("rebuild did not raise busy");
endmodule

bind frustum_plane_cull_unit fpcu_checker u_chk (
  .clk_i, .rst_ni, .start_i, .busy_o, .done_o, .func_i, .element_index_i
);
